@@ rtl/dq_pkg.sv @@
// Shared types and constants for the bounded deque with positional access.
// Holds operation and status codes, the sequencer state type and the result record.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package dq_pkg;

	localparam int DATA_W   = 32;
	localparam int OP_W     = 4;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_INSERT_AT  = 4'd2,
		OP_POP_FRONT  = 4'd3,
		OP_POP_BACK   = 4'd4,
		OP_REMOVE_AT  = 4'd5,
		OP_READ_FRONT = 4'd6,
		OP_READ_BACK  = 4'd7,
		OP_READ_AT    = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_SHIFT_UP,
		S_INS_WRITE,
		S_SHIFT_DOWN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		status_t                  status;
		logic [COUNT_W-1:0]       count;
	} result_t;

endpackage

@@ rtl/dq_mem.sv @@
// Entry store of the deque: one write port and one read port, read data registered.
// Uses dq_pkg for the data width and the default depth only.
module dq_mem #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [dq_pkg::DATA_W-1:0]     wdata,
	input  logic                          re,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [dq_pkg::DATA_W-1:0]     rdata
);

	logic [dq_pkg::DATA_W-1:0] mem [DEPTH];
	logic [dq_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/dq_ctrl.sv @@
// Sequencer of the deque: head pointer, element count and the shift loops.
// Drives the entry store ports of dq_mem and hands a result record to the top level.
// Uses dq_pkg for codes, state and result types.
module dq_ctrl #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dq_pkg::OP_W-1:0]           operation,
	input  logic signed [dq_pkg::DATA_W-1:0]  value,
	input  logic [dq_pkg::POS_W-1:0]          position,
	output logic                              res_valid,
	input  logic                              res_ready,
	output dq_pkg::result_t                   res,
	output logic                              mem_we,
	output logic [$clog2(DEPTH)-1:0]          mem_waddr,
	output logic [dq_pkg::DATA_W-1:0]         mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(DEPTH)-1:0]          mem_raddr,
	input  logic [dq_pkg::DATA_W-1:0]         mem_rdata
);

	localparam int AW   = $clog2(DEPTH);
	localparam int AW1  = AW + 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CW1  = CW + 1;
	localparam int CMPW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;
	localparam int CNTOUTW = dq_pkg::COUNT_W;

	dq_pkg::state_t state_q, state_d;
	dq_pkg::op_t    op_in, op_q;

	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q;
	logic [dq_pkg::DATA_W-1:0] val_q;
	logic signed [dq_pkg::DATA_W-1:0] rdata_q, rdata_d;
	dq_pkg::status_t status_q, status_d;

	logic          acc;
	logic          full, empty;
	logic          pos_le_cnt, pos_lt_cnt, pos_eq_cnt;
	logic [CW-1:0] pos_in;
	logic [AW-1:0] head_dec, head_inc;
	logic [CW-1:0] rd_log, wr_log;
	logic          wr_front;
	logic          more_down, more_up;

	// Logical index to entry address, relative to the front of the ring.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] i);
		logic [AW1-1:0] s;
		s = AW1'(head) + AW1'(i);
		if (s >= AW1'(DEPTH)) begin
			s = s - AW1'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign op_in      = dq_pkg::op_t'(operation);
	assign acc        = in_valid && in_ready;
	assign in_ready   = (state_q == dq_pkg::S_IDLE);
	assign full       = (cnt_q == CW'(DEPTH));
	assign empty      = (cnt_q == '0);
	assign pos_le_cnt = (CMPW'(position) <= CMPW'(cnt_q));
	assign pos_lt_cnt = (CMPW'(position) <  CMPW'(cnt_q));
	assign pos_eq_cnt = (CMPW'(position) == CMPW'(cnt_q));
	assign pos_in     = CW'(position);
	assign head_dec   = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc   = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign more_down  = (CW1'(idx_q) + CW1'(2)) < CW1'(cnt_q);
	assign more_up    = (CW1'(idx_q) != CW1'(pos_q) + CW1'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dq_pkg::S_IDLE: begin
				if (in_valid) begin
					case (op_in)
						dq_pkg::OP_INSERT_AT: begin
							if (!pos_le_cnt || full || pos_eq_cnt) begin
								state_d = dq_pkg::S_FINISH;
							end else begin
								state_d = dq_pkg::S_SHIFT_UP;
							end
						end
						dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
						dq_pkg::OP_READ_FRONT, dq_pkg::OP_READ_BACK: begin
							state_d = empty ? dq_pkg::S_FINISH : dq_pkg::S_FETCH;
						end
						dq_pkg::OP_REMOVE_AT, dq_pkg::OP_READ_AT: begin
							state_d = (empty || !pos_lt_cnt) ? dq_pkg::S_FINISH : dq_pkg::S_FETCH;
						end
						default: begin
							state_d = dq_pkg::S_FINISH;
						end
					endcase
				end
			end
			dq_pkg::S_FETCH: begin
				if (op_q == dq_pkg::OP_REMOVE_AT &&
				    (CW1'(idx_q) + CW1'(1)) < CW1'(cnt_q)) begin
					state_d = dq_pkg::S_SHIFT_DOWN;
				end else begin
					state_d = dq_pkg::S_FINISH;
				end
			end
			dq_pkg::S_SHIFT_UP: begin
				state_d = more_up ? dq_pkg::S_SHIFT_UP : dq_pkg::S_INS_WRITE;
			end
			dq_pkg::S_INS_WRITE: begin
				state_d = dq_pkg::S_FINISH;
			end
			dq_pkg::S_SHIFT_DOWN: begin
				state_d = more_down ? dq_pkg::S_SHIFT_DOWN : dq_pkg::S_FINISH;
			end
			dq_pkg::S_FINISH: begin
				if (res_ready) begin
					state_d = dq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dq_pkg::S_IDLE;
			end
		endcase
	end

	// Memory accesses and register updates.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = mem_rdata;
		rd_log    = '0;
		wr_log    = '0;
		wr_front  = 1'b0;
		head_d    = head_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		rdata_d   = rdata_q;
		status_d  = status_q;
		case (state_q)
			dq_pkg::S_IDLE: begin
				if (in_valid) begin
					rdata_d  = '0;
					status_d = dq_pkg::ST_OK;
					case (op_in)
						dq_pkg::OP_PUSH_FRONT: begin
							if (full) begin
								status_d = dq_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								wr_front  = 1'b1;
								mem_wdata = value;
								head_d    = head_dec;
								cnt_d     = cnt_q + CW'(1);
							end
						end
						dq_pkg::OP_PUSH_BACK: begin
							if (full) begin
								status_d = dq_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								wr_log    = cnt_q;
								mem_wdata = value;
								cnt_d     = cnt_q + CW'(1);
							end
						end
						dq_pkg::OP_INSERT_AT: begin
							if (!pos_le_cnt) begin
								status_d = dq_pkg::ST_RANGE;
							end else if (full) begin
								status_d = dq_pkg::ST_FULL;
							end else if (pos_eq_cnt) begin
								mem_we    = 1'b1;
								wr_log    = cnt_q;
								mem_wdata = value;
								cnt_d     = cnt_q + CW'(1);
							end else begin
								mem_re = 1'b1;
								rd_log = cnt_q - CW'(1);
								idx_d  = cnt_q;
							end
						end
						dq_pkg::OP_POP_FRONT, dq_pkg::OP_READ_FRONT: begin
							if (empty) begin
								status_d = dq_pkg::ST_EMPTY;
							end else begin
								mem_re = 1'b1;
								idx_d  = '0;
							end
						end
						dq_pkg::OP_POP_BACK, dq_pkg::OP_READ_BACK: begin
							if (empty) begin
								status_d = dq_pkg::ST_EMPTY;
							end else begin
								mem_re = 1'b1;
								rd_log = cnt_q - CW'(1);
								idx_d  = cnt_q - CW'(1);
							end
						end
						dq_pkg::OP_REMOVE_AT, dq_pkg::OP_READ_AT: begin
							if (empty) begin
								status_d = dq_pkg::ST_EMPTY;
							end else if (!pos_lt_cnt) begin
								status_d = dq_pkg::ST_RANGE;
							end else begin
								mem_re = 1'b1;
								rd_log = pos_in;
								idx_d  = pos_in;
							end
						end
						default: begin
						end
					endcase
				end
			end
			dq_pkg::S_FETCH: begin
				rdata_d = mem_rdata;
				case (op_q)
					dq_pkg::OP_POP_FRONT: begin
						head_d = head_inc;
						cnt_d  = cnt_q - CW'(1);
					end
					dq_pkg::OP_POP_BACK: begin
						cnt_d = cnt_q - CW'(1);
					end
					dq_pkg::OP_REMOVE_AT: begin
						if ((CW1'(idx_q) + CW1'(1)) < CW1'(cnt_q)) begin
							mem_re = 1'b1;
							rd_log = idx_q + CW'(1);
						end else begin
							cnt_d = cnt_q - CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			dq_pkg::S_SHIFT_UP: begin
				mem_we = 1'b1;
				wr_log = idx_q;
				if (more_up) begin
					mem_re = 1'b1;
					rd_log = idx_q - CW'(2);
					idx_d  = idx_q - CW'(1);
				end
			end
			dq_pkg::S_INS_WRITE: begin
				mem_we    = 1'b1;
				wr_log    = pos_q;
				mem_wdata = val_q;
				cnt_d     = cnt_q + CW'(1);
			end
			dq_pkg::S_SHIFT_DOWN: begin
				mem_we = 1'b1;
				wr_log = idx_q;
				idx_d  = idx_q + CW'(1);
				if (more_down) begin
					mem_re = 1'b1;
					rd_log = idx_q + CW'(2);
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_raddr = phys(head_q, rd_log);
	assign mem_waddr = wr_front ? head_dec : phys(head_q, wr_log);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dq_pkg::S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		rdata_q  <= rdata_d;
		status_q <= status_d;
		if (acc) begin
			op_q  <= op_in;
			val_q <= value;
			pos_q <= pos_in;
		end
	end

	assign res_valid   = (state_q == dq_pkg::S_FINISH);
	assign res.data    = rdata_q;
	assign res.status  = status_q;
	assign res.count   = CNTOUTW'(cnt_q);

	// The element count never goes past the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW1'(cnt_q) <= CW1'(DEPTH))
		else $error("element count above capacity");

	// The ring head always names a real entry.
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		AW1'(head_q) < AW1'(DEPTH))
		else $error("head pointer out of range");

	// One transaction moves the count by at most one.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |->
		(CW1'(cnt_q) == CW1'($past(cnt_q)) + CW1'(1) ||
		 CW1'(cnt_q) + CW1'(1) == CW1'($past(cnt_q))))
		else $error("element count jumped");

	// The memory is left alone once the result is ready.
	a_no_write_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dq_pkg::S_FINISH) |-> (!mem_we && !mem_re))
		else $error("memory access while holding a result");

endmodule

@@ rtl/bounded_deque_with_positional_access.sv @@
// Top level of the bounded deque with positional access.
// Instantiates dq_ctrl (sequencer) and dq_mem (entry store) and holds the output register.
// Uses dq_pkg for widths, the default depth and the result record.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | to block  | in_valid / in_ready | operation[3:0] value[31:0] position[4:0]
//   out     | from block| out_valid/out_ready | data[31:0] status[1:0] count[4:0]
//
// Sequence: an operation with no memory read (push at either end, insert at the back,
// any rejected operation) goes from acceptance straight to the finish state; pops and
// reads pass a fetch state first. Insert at a position p below the count shifts the
// entries from p upward one entry per cycle through the memory ports, then writes the
// value; remove at p fetches the entry, then shifts the entries above p downward one
// entry per cycle. The result waits in the finish state while the output register stalls.
// Reset: arst_n clears the count, the head pointer and all handshake state; the
// entry store is not cleared, since only entries below the count are ever read.
// Stalls: a new transaction is accepted while a finished result still waits in the
// output register; the block holds its next result internally until that one leaves.
module bounded_deque_with_positional_access #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dq_pkg::OP_W-1:0]           operation,
	input  logic signed [dq_pkg::DATA_W-1:0]  value,
	input  logic [dq_pkg::POS_W-1:0]          position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [dq_pkg::DATA_W-1:0]  data,
	output logic [1:0]                        status,
	output logic [dq_pkg::COUNT_W-1:0]        count
);

	localparam int AW = $clog2(DEPTH);

	// Result handoff between the sequencer and the output register.
	dq_pkg::result_t res;
	dq_pkg::result_t out_q;
	logic            res_valid;
	logic            res_ready;
	logic            out_valid_q;

	// Entry store ports.
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [dq_pkg::DATA_W-1:0] mem_wdata;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;
	logic [dq_pkg::DATA_W-1:0] mem_rdata;

	dq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.value     (value),
		.position  (position),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	dq_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The output register takes a new result when it is empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload only; it is meaningful while out_valid_q is set.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = out_q.data;
	assign status    = out_q.status;
	assign count     = out_q.count;

	// A result waiting in the sequencer is never dropped: it leaves only into a free register.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result left the sequencer without a free output register");

	// The sequencer takes no transaction while it still holds a result.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready)
		else $error("transaction accepted while a result is pending");

	// A loaded output register is visible in the next cycle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> out_valid)
		else $error("loaded result not presented");

endmodule
